// File: rtl/kmd_pkg.sv
package kmd_pkg;

	// Default geometry and timing
	localparam int NUM_KEYS_DEF     = 36;
	localparam int FILTER_TICKS_DEF = 5;
	localparam int RING_DEPTH_DEF   = 16;

	// Rows per column group of the matrix
	localparam int MATRIX_ROWS = 6;

	// Fixed field widths
	localparam int LINE_W  = 36;
	localparam int CODE_W  = 7;
	localparam int DEB_W   = 4;
	localparam int LONG_W  = 16;
	localparam int REP_W   = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Command queue between front and back
	localparam int Q_DEPTH = 2;

	// Register reset values
	localparam logic [LONG_W-1:0] LONG_RESET = LONG_W'(100);
	localparam logic [REP_W-1:0]  REP_RESET  = '0;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_READ_A = 2'd1,
		CMD_READ_B = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LONG_PRESS = 2'd0,
		CFG_REPEAT     = 2'd1
	} cfg_idx_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [LINE_W-1:0] line_active;
	} cmd_item_t;

	typedef struct packed {
		logic [CODE_W-1:0] key_code;
		logic [LINE_W-1:0] key_down_flags;
	} rsp_item_t;

	// Classified command as queued for the back end
	typedef struct packed {
		cmd_t              cmd;
		logic [LINE_W-1:0] down;
	} q_entry_t;

	// Queue status towards the back end
	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_status_t;

	typedef struct packed {
		logic [LONG_W-1:0] long_press_ticks;
		logic [REP_W-1:0]  repeat_period;
	} cfg_t;

	// Per-key debounce state held in the key memory
	typedef struct packed {
		logic [DEB_W-1:0]  deb;
		logic [LONG_W-1:0] hold;
		logic [REP_W-1:0]  rep;
	} key_state_t;

endpackage

// File: rtl/key_matrix_debounce_event_fifo_unit.sv
// Scan tick: every key is visited, with an extra step for each key raising two events.
// Read: a ring read unless the ring is empty, then the result. Clear: the result alone.
// One command runs at a time. Keys go one per cycle bar that step, via a read and a write port.
// A two-entry command queue lets commands transfer in while a result waits on the output.
// Reset (arst_n low, asynchronous) clears key valid bits, pressed flags, ring pointers and
// control registers at once; no clearing pass. Ring contents stay undefined until written.
module key_matrix_debounce_event_fifo_unit #(
	parameter int NUM_KEYS     = kmd_pkg::NUM_KEYS_DEF,
	parameter int FILTER_TICKS = kmd_pkg::FILTER_TICKS_DEF,
	parameter int RING_DEPTH   = kmd_pkg::RING_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	output logic                              cmd_stall,
	input  kmd_pkg::cmd_item_t                cmd_data,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output kmd_pkg::rsp_item_t                rsp_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [kmd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [kmd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	kmd_pkg::cfg_t      cfg_q;
	kmd_pkg::q_entry_t  q_wdata;
	kmd_pkg::q_status_t q_status;
	logic               q_push, q_full, q_pop;

	// Configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_ticks <= kmd_pkg::LONG_RESET;
			cfg_q.repeat_period    <= kmd_pkg::REP_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == kmd_pkg::CFG_LONG_PRESS) begin
				cfg_q.long_press_ticks <= cfg_data[kmd_pkg::LONG_W-1:0];
			end else if (cfg_index == kmd_pkg::CFG_REPEAT) begin
				cfg_q.repeat_period <= cfg_data[kmd_pkg::REP_W-1:0];
			end
		end
	end

	kmd_front #(
		.NUM_KEYS (NUM_KEYS)
	) u_front (
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_data  (cmd_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	kmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.status (q_status)
	);

	kmd_back #(
		.NUM_KEYS     (NUM_KEYS),
		.FILTER_TICKS (FILTER_TICKS),
		.RING_DEPTH   (RING_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.q_pop     (q_pop),
		.cfg       (cfg_q),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

endmodule

// File: rtl/kmd_front.sv
module kmd_front #(
	parameter int NUM_KEYS = kmd_pkg::NUM_KEYS_DEF
) (
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  kmd_pkg::cmd_item_t  cmd_data,
	input  logic                q_full,
	output logic                q_push,
	output kmd_pkg::q_entry_t   q_wdata
);

	logic [NUM_KEYS-1:0] down;
	logic [NUM_KEYS-1:0] lines;

	assign lines = cmd_data.line_active[NUM_KEYS-1:0];

	// Only the lowest active row of each column group counts as pressed
	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
		localparam int Base = (k / kmd_pkg::MATRIX_ROWS) * kmd_pkg::MATRIX_ROWS;
		localparam logic [NUM_KEYS-1:0] Below =
			NUM_KEYS'(((64'd1 << (k - Base)) - 64'd1) << Base);
		assign down[k] = lines[k] && ((lines & Below) == '0);
	end

	// Transfer into the queue whenever it has room
	assign cmd_stall = q_full;
	assign q_push    = cmd_valid && !q_full;

	always_comb begin
		q_wdata      = '0;
		q_wdata.cmd  = cmd_data.cmd;
		q_wdata.down = kmd_pkg::LINE_W'(down);
	end

endmodule

// File: rtl/kmd_queue.sv
module kmd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  kmd_pkg::q_entry_t   wdata,
	output logic                full,
	input  logic                pop,
	output kmd_pkg::q_status_t  status
);

	localparam int PW = (kmd_pkg::Q_DEPTH > 1) ? $clog2(kmd_pkg::Q_DEPTH) : 1;
	localparam int CW = $clog2(kmd_pkg::Q_DEPTH + 1);

	kmd_pkg::q_entry_t slot_q [kmd_pkg::Q_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = count_q == CW'(kmd_pkg::Q_DEPTH);
	assign do_push = push && !full;
	assign do_pop  = pop && (count_q != '0);

	assign status.valid = count_q != '0;
	assign status.entry = slot_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(kmd_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(kmd_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// File: rtl/kmd_back.sv
module kmd_back #(
	parameter int NUM_KEYS     = kmd_pkg::NUM_KEYS_DEF,
	parameter int FILTER_TICKS = kmd_pkg::FILTER_TICKS_DEF,
	parameter int RING_DEPTH   = kmd_pkg::RING_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  kmd_pkg::q_status_t  q_status,
	output logic                q_pop,
	input  kmd_pkg::cfg_t       cfg,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output kmd_pkg::rsp_item_t  rsp_data
);

	localparam int KW = $clog2(NUM_KEYS);
	localparam int RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam logic [kmd_pkg::DEB_W-1:0] FILT  = kmd_pkg::DEB_W'(FILTER_TICKS);
	localparam logic [kmd_pkg::DEB_W-1:0] FILT2 = kmd_pkg::DEB_W'(2 * FILTER_TICKS);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EX   = 5'b00010,
		S_P2   = 5'b00100,
		S_RING = 5'b01000,
		S_OUT  = 5'b10000
	} bk_state_t;

	bk_state_t state_q;

	// Key state memory with per-entry valid bits
	kmd_pkg::key_state_t kmem [NUM_KEYS];
	kmd_pkg::key_state_t kmem_rd_q;
	logic [NUM_KEYS-1:0] kvalid_q;
	logic [NUM_KEYS-1:0] pflag_q;
	logic [KW-1:0]       kaddr;
	logic                kwr;

	// Event ring
	logic [kmd_pkg::CODE_W-1:0] ring [RING_DEPTH];
	logic [kmd_pkg::CODE_W-1:0] ring_rd_q;
	logic [kmd_pkg::CODE_W-1:0] ring_wdata;
	logic [RW-1:0] ring_raddr;
	logic          ring_we;
	logic [RW-1:0] wp_q, rpa_q, rpb_q;

	// Sequencer registers
	logic [KW-1:0]              k_q;
	logic [kmd_pkg::CODE_W-1:0] base_q;
	logic [NUM_KEYS-1:0]        down_q;
	logic [kmd_pkg::CODE_W-1:0] code_q;
	logic [kmd_pkg::CODE_W-1:0] c2_q;
	logic                       rsp_valid_q;
	kmd_pkg::rsp_item_t         rsp_data_q;

	logic          out_free, last_key;
	logic [KW-1:0] k_nx;
	kmd_pkg::cmd_t q_cmd;

	// Per-key update results
	kmd_pkg::key_state_t cur, nx;
	logic                nx_p, has1, has2;
	logic [kmd_pkg::CODE_W-1:0] c1, c2;
	logic [kmd_pkg::CODE_W-1:0] code_press, code_rel, code_long;
	logic [kmd_pkg::LONG_W-1:0] hold_inc;
	logic [kmd_pkg::REP_W-1:0]  rep_inc;

	function automatic logic [RW-1:0] ring_next(input logic [RW-1:0] p);
		ring_next = (p == RW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign last_key = k_q == KW'(NUM_KEYS - 1);
	assign k_nx     = last_key ? '0 : k_q + 1'b1;
	assign q_cmd    = q_status.entry.cmd;

	assign code_press = base_q + kmd_pkg::CODE_W'(1);
	assign code_rel   = base_q + kmd_pkg::CODE_W'(2);
	assign code_long  = base_q + kmd_pkg::CODE_W'(3);

	// Debounce, long press and repeat for the key under the sequencer
	always_comb begin
		logic ev_press, ev_long, ev_rel;
		ev_press = 1'b0;
		ev_long  = 1'b0;
		ev_rel   = 1'b0;
		if (kvalid_q[k_q]) begin
			cur = kmem_rd_q;
		end else begin
			cur.deb  = FILT;
			cur.hold = '0;
			cur.rep  = '0;
		end
		nx       = cur;
		nx_p     = pflag_q[k_q];
		hold_inc = cur.hold + 1'b1;
		rep_inc  = cur.rep + 1'b1;
		if (down_q[k_q]) begin
			if (cur.deb < FILT) begin
				nx.deb = FILT;
			end else if (cur.deb < FILT2) begin
				nx.deb = cur.deb + 1'b1;
			end else begin
				if (!pflag_q[k_q]) begin
					nx_p     = 1'b1;
					ev_press = 1'b1;
				end
				if (cfg.long_press_ticks != '0) begin
					if (cur.hold < cfg.long_press_ticks) begin
						nx.hold = hold_inc;
						ev_long = hold_inc == cfg.long_press_ticks;
					end else if (cfg.repeat_period != '0) begin
						nx.rep = rep_inc;
						if (rep_inc >= cfg.repeat_period) begin
							nx.rep   = '0;
							ev_press = 1'b1;
						end
					end
				end
			end
		end else begin
			if (cur.deb > FILT) begin
				nx.deb = FILT;
			end else if (cur.deb != '0) begin
				nx.deb = cur.deb - 1'b1;
			end else if (pflag_q[k_q]) begin
				nx_p   = 1'b0;
				ev_rel = 1'b1;
			end
			nx.hold = '0;
			nx.rep  = '0;
		end
		// press comes before long when both fire in one tick
		has1 = ev_press || ev_long || ev_rel;
		has2 = ev_press && ev_long;
		c2   = code_long;
		if (ev_press) begin
			c1 = code_press;
		end else if (ev_long) begin
			c1 = code_long;
		end else begin
			c1 = code_rel;
		end
	end

	// Memory addressing and write strobes
	always_comb begin
		q_pop      = (state_q == S_IDLE) && q_status.valid;
		kwr        = state_q == S_EX;
		ring_we    = ((state_q == S_EX) && has1) || (state_q == S_P2);
		ring_wdata = (state_q == S_P2) ? c2_q : c1;
		ring_raddr = (q_cmd == kmd_pkg::CMD_READ_B) ? rpb_q : rpa_q;
		unique case (state_q)
			S_IDLE: kaddr = '0;
			S_EX:   kaddr = has2 ? k_q : k_nx;
			S_P2:   kaddr = k_nx;
			default: kaddr = k_q;
		endcase
	end

	always_ff @(posedge clk) begin
		kmem_rd_q <= kmem[kaddr];
		if (kwr) begin
			kmem[k_q] <= nx;
		end
	end

	always_ff @(posedge clk) begin
		ring_rd_q <= ring[ring_raddr];
		if (ring_we) begin
			ring[wp_q] <= ring_wdata;
		end
	end

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kvalid_q    <= '0;
			pflag_q     <= '0;
			wp_q        <= '0;
			rpa_q       <= '0;
			rpb_q       <= '0;
			k_q         <= '0;
			base_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// a new result may load in the cycle the old one transfers out
			if ((state_q == S_OUT) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_status.valid) begin
						unique case (q_cmd)
							kmd_pkg::CMD_TICK: begin
								k_q     <= '0;
								base_q  <= '0;
								state_q <= S_EX;
							end
							kmd_pkg::CMD_READ_A: begin
								if (rpa_q == wp_q) begin
									state_q <= S_OUT;
								end else begin
									rpa_q   <= ring_next(rpa_q);
									state_q <= S_RING;
								end
							end
							kmd_pkg::CMD_READ_B: begin
								if (rpb_q == wp_q) begin
									state_q <= S_OUT;
								end else begin
									rpb_q   <= ring_next(rpb_q);
									state_q <= S_RING;
								end
							end
							kmd_pkg::CMD_CLEAR: begin
								rpa_q   <= wp_q;
								state_q <= S_OUT;
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_EX: begin
					pflag_q[k_q]  <= nx_p;
					kvalid_q[k_q] <= 1'b1;
					if (has1) begin
						wp_q <= ring_next(wp_q);
					end
					if (has2) begin
						state_q <= S_P2;
					end else if (last_key) begin
						state_q <= S_OUT;
					end else begin
						k_q    <= k_nx;
						base_q <= base_q + kmd_pkg::CODE_W'(3);
					end
				end
				S_P2: begin
					wp_q <= ring_next(wp_q);
					if (last_key) begin
						state_q <= S_OUT;
					end else begin
						k_q     <= k_nx;
						base_q  <= base_q + kmd_pkg::CODE_W'(3);
						state_q <= S_EX;
					end
				end
				S_RING: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			down_q <= q_status.entry.down[NUM_KEYS-1:0];
			code_q <= '0;
		end
		if (state_q == S_EX) begin
			c2_q <= c2;
		end
		if (state_q == S_RING) begin
			code_q <= ring_rd_q;
		end
		if ((state_q == S_OUT) && out_free) begin
			rsp_data_q.key_code       <= code_q;
			rsp_data_q.key_down_flags <= kmd_pkg::LINE_W'(pflag_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

endmodule
